### rtl/rid_pkg.sv
// Shared types, codes and defaults for the reversible indexed deque.
package rid_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W   = 3;
    localparam int POS_W  = 10;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 11;
    localparam int KIND_W = 3;

    // command op codes
    localparam logic [OP_W-1:0] OP_PUSH_L = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_R = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_L  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_R  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;
    localparam logic [OP_W-1:0] OP_REV    = 3'd6;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    // decoded operation kinds handed from front to back
    localparam logic [KIND_W-1:0] K_NOP   = 3'd0;
    localparam logic [KIND_W-1:0] K_PUSH  = 3'd1;
    localparam logic [KIND_W-1:0] K_POP   = 3'd2;
    localparam logic [KIND_W-1:0] K_READ  = 3'd3;
    localparam logic [KIND_W-1:0] K_WRITE = 3'd4;
    localparam logic [KIND_W-1:0] K_REV   = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [VAL_W-1:0] read_data;
        logic [VAL_W-1:0] left_end;
        logic [VAL_W-1:0] right_end;
        logic [CNT_W-1:0] count;
        logic             is_reversed;
    } rsp_t;

    // classified command: kind plus logical side for push and pop
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              logical_left;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  value;
    } cls_t;

    // queue handshake between front and back
    typedef struct packed {
        logic valid;
        cls_t item;
    } qout_t;

endpackage

### rtl/rid_front.sv
// Front end: accepts command beats, classifies them and queues them for the back end.
module rid_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rid_pkg::cmd_t cmd,
    output rid_pkg::qout_t qout,
    input  logic          q_pop
);
    import rid_pkg::*;

    localparam int QD = 2;

    cls_t             entry_reg [QD];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       fill_reg, fill_next;
    cls_t             cls;
    logic             push;

    // decode the op code into a kind and a logical side
    always_comb
    begin
        cls.kind         = K_NOP;
        cls.logical_left = 1'b0;
        cls.position     = cmd.position;
        cls.value        = cmd.value;
        unique case (cmd.op)
            OP_PUSH_L:
            begin
                cls.kind         = K_PUSH;
                cls.logical_left = 1'b1;
            end
            OP_PUSH_R: cls.kind = K_PUSH;
            OP_POP_L:
            begin
                cls.kind         = K_POP;
                cls.logical_left = 1'b1;
            end
            OP_POP_R:  cls.kind = K_POP;
            OP_READ:   cls.kind = K_READ;
            OP_WRITE:  cls.kind = K_WRITE;
            OP_REV:    cls.kind = K_REV;
            default:   cls.kind = K_NOP;
        endcase
    end

    assign busy = (fill_reg == 2'(QD));
    assign push = start && !busy;

    always_comb
    begin
        wr_ptr_next = push  ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cls;
        end
    end

    assign qout.valid = (fill_reg != 2'd0);
    assign qout.item  = entry_reg[rd_ptr_reg];

endmodule

### rtl/rid_back.sv
// Back end: element store, end registers and the execution sequencer.
module rid_back #(
    parameter int CAPACITY   = rid_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = rid_pkg::DATA_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rid_pkg::qout_t qout,
    output logic           q_pop,
    output logic           done,
    output rid_pkg::rsp_t  rsp
);
    import rid_pkg::*;

    localparam int PTR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_IW = $clog2(CAPACITY + 1);
    localparam int CW     = CNT_IW + POS_W;

    localparam logic S_EXEC = 1'b0;
    localparam logic S_MEM  = 1'b1;

    function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] head,
                                                 input logic [PTR_W-1:0] phys);
        logic [PTR_W:0] sum;
        sum = {1'b0, head} + {1'b0, phys};
        if (sum >= (PTR_W+1)'(CAPACITY))
        begin
            sum = sum - (PTR_W+1)'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] mem_q;

    logic                  state_reg, state_next;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [CNT_IW-1:0]     count_reg, count_next;
    logic                  rev_reg, rev_next;
    logic [DATA_WIDTH-1:0] pl_reg, pl_next;
    logic [DATA_WIDTH-1:0] pr_reg, pr_next;
    logic                  pend_read_reg, pend_read_next;
    logic                  pend_left_reg, pend_left_next;
    rsp_t                  rsp_reg, rsp_next;
    logic                  done_reg;

    logic                  mem_we, mem_re;
    logic [PTR_W-1:0]      mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0] v_in;
    logic [DATA_WIDTH-1:0] rd_val;
    logic [ST_W-1:0]       status;
    logic                  emit;

    logic                  phys_left, full, empty, in_range;
    logic [PTR_W-1:0]      head_dec, head_inc, slot_tail, slot_last2, slot_acc;
    logic [CNT_IW-1:0]     pos_c, t_full, last_idx;
    logic [DATA_WIDTH-1:0] le_val, re_val;

    assign v_in       = DATA_WIDTH'(qout.item.value);
    assign phys_left  = qout.item.logical_left ^ rev_reg;
    assign full       = (count_reg == CNT_IW'(CAPACITY));
    assign empty      = (count_reg == '0);
    assign in_range   = CW'(qout.item.position) < CW'(count_reg);
    assign head_dec   = (head_reg == '0) ? PTR_W'(CAPACITY - 1) : head_reg - PTR_W'(1);
    assign head_inc   = (head_reg == PTR_W'(CAPACITY - 1)) ? '0 : head_reg + PTR_W'(1);
    assign slot_tail  = slot_of(head_reg, PTR_W'(count_reg));
    assign slot_last2 = slot_of(head_reg, PTR_W'(count_reg - CNT_IW'(2)));
    assign last_idx   = count_reg - CNT_IW'(1);
    assign pos_c      = CNT_IW'(qout.item.position);
    assign t_full     = rev_reg ? (last_idx - pos_c) : pos_c;
    assign slot_acc   = slot_of(head_reg, PTR_W'(t_full));

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        pl_next        = pl_reg;
        pr_next        = pr_reg;
        pend_read_next = pend_read_reg;
        pend_left_next = pend_left_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = slot_acc;
        mem_raddr      = slot_acc;
        status         = ST_OK;
        rd_val         = '0;
        emit           = 1'b0;
        q_pop          = 1'b0;
        unique case (state_reg)
            S_EXEC:
            begin
                if (qout.valid)
                begin
                    q_pop = 1'b1;
                    emit  = 1'b1;
                    case (qout.item.kind)
                        K_PUSH:
                        begin
                            if (full)
                            begin
                                status = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_IW'(1);
                                if (phys_left)
                                begin
                                    head_next = head_dec;
                                    mem_waddr = head_dec;
                                    pl_next   = v_in;
                                end
                                else
                                begin
                                    mem_waddr = slot_tail;
                                    pr_next   = v_in;
                                end
                                if (empty)
                                begin
                                    pl_next = v_in;
                                    pr_next = v_in;
                                end
                            end
                        end
                        K_POP:
                        begin
                            if (empty)
                            begin
                                status = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = last_idx;
                                if (phys_left)
                                begin
                                    head_next = head_inc;
                                end
                                if (last_idx == '0)
                                begin
                                    pl_next = '0;
                                    pr_next = '0;
                                end
                                else
                                begin
                                    // new end comes out of the store next cycle
                                    emit           = 1'b0;
                                    mem_re         = 1'b1;
                                    mem_raddr      = phys_left ? head_inc : slot_last2;
                                    pend_read_next = 1'b0;
                                    pend_left_next = phys_left;
                                    state_next     = S_MEM;
                                end
                            end
                        end
                        K_READ:
                        begin
                            if (!in_range)
                            begin
                                status = ST_RANGE;
                            end
                            else
                            begin
                                emit           = 1'b0;
                                mem_re         = 1'b1;
                                pend_read_next = 1'b1;
                                state_next     = S_MEM;
                            end
                        end
                        K_WRITE:
                        begin
                            if (!in_range)
                            begin
                                status = ST_RANGE;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                if (t_full == '0)
                                begin
                                    pl_next = v_in;
                                end
                                if (t_full == last_idx)
                                begin
                                    pr_next = v_in;
                                end
                            end
                        end
                        K_REV: rev_next = !rev_reg;
                        default: status = ST_OK;
                    endcase
                end
            end
            S_MEM:
            begin
                emit       = 1'b1;
                state_next = S_EXEC;
                if (pend_read_reg)
                begin
                    rd_val = mem_q;
                end
                else if (pend_left_reg)
                begin
                    pl_next = mem_q;
                end
                else
                begin
                    pr_next = mem_q;
                end
            end
            default: state_next = S_EXEC;
        endcase
    end

    // result word built from the state after the step
    always_comb
    begin
        le_val = '0;
        re_val = '0;
        if (count_next != '0)
        begin
            le_val = rev_next ? pr_next : pl_next;
            re_val = rev_next ? pl_next : pr_next;
        end
        rsp_next.status      = status;
        rsp_next.read_data   = VAL_W'(rd_val);
        rsp_next.left_end    = VAL_W'(le_val);
        rsp_next.right_end   = VAL_W'(re_val);
        rsp_next.count       = CNT_W'(count_next);
        rsp_next.is_reversed = rev_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EXEC;
            head_reg      <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            pl_reg        <= '0;
            pr_reg        <= '0;
            pend_read_reg <= 1'b0;
            pend_left_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            pl_reg        <= pl_next;
            pr_reg        <= pr_next;
            pend_read_reg <= pend_read_next;
            pend_left_reg <= pend_left_next;
            done_reg      <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= v_in;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

### rtl/reversible_indexed_deque_unit.sv
// Top level of the reversible indexed deque: front queue plus execution back end.
//
// Usage:
//   Command channel: drive cmd and raise start; the beat is taken at a rising edge
//   where start is high and busy is low. busy rises while the two-entry command
//   queue between front and back is full.
//   Result channel: done pulses for one cycle with the result beat on rsp. Every
//   command beat yields exactly one result beat, in order. The receiver cannot
//   stall; results must be taken in the cycle they are shown.
// Execution steps:
//   Push, write, reverse and unused codes: the accepted beat passes the command
//   queue, runs in the execution state alone and is registered as the result.
//   Pop (with elements left) and in-range read: execution state, then memory state,
//   which reads the element store's registered port and takes no new command.
//   Queued commands add their wait in front of the back end.
// Reset:
//   rst_n clears the queue, the count, the head, the reversal flag and the end
//   registers; the element store is left as is and no clearing pass runs.
module reversible_indexed_deque_unit #(
    parameter int CAPACITY   = rid_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = rid_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rid_pkg::cmd_t cmd,
    output logic          done,
    output rid_pkg::rsp_t rsp
);
    import rid_pkg::*;

    qout_t qout;
    logic  q_pop;

    // classify and hold incoming command beats
    rid_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .qout  (qout),
        .q_pop (q_pop)
    );

    // drain the queue, update the store and produce one result beat per command
    rid_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .qout  (qout),
        .q_pop (q_pop),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

### rtl/rid_checker.sv
// Port-level checks for the reversible indexed deque, bound to the top level.
module rid_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input rid_pkg::cmd_t cmd,
    input logic          done,
    input rid_pkg::rsp_t rsp
);
    import rid_pkg::*;

    // an accepted command beat carries no unknown bits
    a_known_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> !$isunknown(cmd))
        else $error("unknown bits on an accepted command beat");

    // an empty store reports zero at both ends
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.count == '0) |-> (rsp.left_end == '0) && (rsp.right_end == '0))
        else $error("nonzero end value with empty store");

    // data comes back only from a successful access
    a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.read_data != '0) |-> (rsp.status == ST_OK))
        else $error("read data on a failed beat");

    // a pop that found nothing leaves the store empty
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.status == ST_EMPTY) |-> (rsp.count == '0))
        else $error("empty status with elements present");

    // a single element is both ends
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp.count == CNT_W'(1)) |-> (rsp.left_end == rsp.right_end))
        else $error("single element with differing ends");

endmodule

bind reversible_indexed_deque_unit rid_checker u_rid_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
);
